@@ rtl/pngcp_pkg.sv @@
package pngcp_pkg;

  localparam logic [31:0] KIND_IHDR = 32'h49484452;
  localparam logic [31:0] KIND_PLTE = 32'h504C5445;
  localparam logic [31:0] KIND_IDAT = 32'h49444154;
  localparam logic [31:0] KIND_IEND = 32'h49454E44;
  localparam logic [31:0] KIND_TRNS = 32'h74524E53;

  localparam logic [1:0] RES_PIXEL = 2'd0;
  localparam logic [1:0] RES_CHUNK = 2'd1;
  localparam logic [1:0] RES_DONE  = 2'd2;
  localparam logic [1:0] RES_ERROR = 2'd3;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_INVALID  = 2'd1;
  localparam logic [1:0] ERR_UNSUPP   = 2'd2;
  localparam logic [1:0] ERR_TRUNC    = 2'd3;

  localparam logic [7:0] COLOR_GRAY  = 8'd0;
  localparam logic [7:0] COLOR_RGB   = 8'd2;
  localparam logic [7:0] COLOR_PAL   = 8'd3;
  localparam logic [7:0] COLOR_GRAYA = 8'd4;
  localparam logic [7:0] COLOR_RGBA  = 8'd6;

  localparam logic [7:0] SAMPLE_BITS = 8'd8;
  localparam logic [7:0] FULL_BYTE = 8'd255;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0: v = 8'h89;
      3'd1: v = 8'h50;
      3'd2: v = 8'h4E;
      3'd3: v = 8'h47;
      3'd4: v = 8'h0D;
      3'd5: v = 8'h0A;
      3'd6: v = 8'h1A;
      default: v = 8'h0A;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  // Residue mod 3 of a 10-bit value: powers of four are all one mod 3.
  function automatic logic [1:0] mod3(input logic [9:0] v);
    logic [3:0] s;
    logic [2:0] t;
    s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]) + 4'(v[9:8]);
    t = 3'(s[1:0]) + 3'(s[3:2]);
    if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

endpackage

@@ rtl/pngcp_ram.sv @@
module pngcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/png_chunk_parser_pixel_unpack.sv @@
// A result is registered in the first stage, then in the output register. Throughput:
// one byte per cycle while out_tready does not stall the output; the palette lookup of an
// indexed pixel uses the registered read port of the palette memories in the first stage.
// Reset (rst_n low at a clock edge) returns the parser to the signature check and empties
// both pipeline stages; palette contents are not cleared and need no clearing pass.
module png_chunk_parser_pixel_unpack #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // stream_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
                                  // [33:32] error_code, [65:34] chunk_code, rest zero
  output logic [1:0]  out_tuser   // [1:0] result_kind
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CW = $clog2(PALETTE_DEPTH + 1);
  localparam logic [31:0] PLTE_MAX_LEN = 32'(3 * PALETTE_DEPTH);

  typedef enum logic [2:0] {PH_SIG, PH_LEN, PH_TYPE, PH_DATA, PH_CRC, PH_DONE} phase_t;

  phase_t       phase_r, phase_nxt;
  logic [31:0]  cnt_r, cnt_nxt;
  logic [31:0]  len_r, len_nxt;
  logic [1:0]   len_m3_r, len_m3_nxt;
  logic [31:0]  kind_r, kind_nxt;
  logic [31:0]  crc_r, crc_nxt;
  logic [31:0]  crc_rx_r, crc_rx_nxt;
  logic [31:0]  width_r, width_nxt;
  logic [31:0]  height_r, height_nxt;
  logic [7:0]   color_r, color_nxt;
  logic [CW-1:0] pal_cnt_r, pal_cnt_nxt;
  logic [1:0]   pal_sub_r, pal_sub_nxt;
  logic [15:0]  pal_rg_r, pal_rg_nxt;
  logic [23:0]  gather_r, gather_nxt;
  logic [1:0]   gcnt_r, gcnt_nxt;
  logic [63:0]  total_r, total_nxt;
  logic         failed_r, failed_nxt;
  logic [63:0]  exp_pix_r;
  logic [65:0]  exp_bytes_r;

  // First stage: result of the byte just taken; second stage: output register.
  logic         s1_valid_r, s1_lookup_r;
  logic [1:0]   s1_kind_r, s1_err_r;
  logic [31:0]  s1_rgba_r, s1_code_r;
  logic         out_valid_r;
  logic [1:0]   out_kind_r, out_err_r;
  logic [31:0]  out_rgba_r, out_code_r;

  logic         accept, s1_adv;
  logic         res_v, res_lookup, err_v;
  logic [1:0]   res_kind, res_err;
  logic [31:0]  res_rgba, res_code;
  logic [7:0]   b;
  logic [31:0]  cnt_inc;
  logic [7:0]   bpp;
  logic         rgb_we, a_we, rd_en;
  logic [AW-1:0] rgb_waddr, a_waddr, raddr;
  logic [23:0]  rgb_wdata, rgb_rdata;
  logic [7:0]   a_wdata, a_rdata;
  logic [65:0]  exp_bytes;

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign accept    = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign cnt_inc   = cnt_r + 32'd1;

  always_comb begin
    case (color_r)
      pngcp_pkg::COLOR_RGB:  bpp = 8'd3;
      pngcp_pkg::COLOR_PAL:  bpp = 8'd1;
      pngcp_pkg::COLOR_RGBA: bpp = 8'd4;
      default:               bpp = 8'd0;
    endcase
    case (color_r)
      pngcp_pkg::COLOR_RGB:  exp_bytes = {1'b0, exp_pix_r, 1'b0} + {2'b00, exp_pix_r};
      pngcp_pkg::COLOR_RGBA: exp_bytes = {exp_pix_r, 2'b00};
      default:               exp_bytes = {2'b00, exp_pix_r};
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    len_nxt     = len_r;
    len_m3_nxt  = len_m3_r;
    kind_nxt    = kind_r;
    crc_nxt     = crc_r;
    crc_rx_nxt  = crc_rx_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    color_nxt   = color_r;
    pal_cnt_nxt = pal_cnt_r;
    pal_sub_nxt = pal_sub_r;
    pal_rg_nxt  = pal_rg_r;
    gather_nxt  = gather_r;
    gcnt_nxt    = gcnt_r;
    total_nxt   = total_r;
    failed_nxt  = failed_r;
    res_v       = 1'b0;
    res_lookup  = 1'b0;
    res_kind    = pngcp_pkg::RES_PIXEL;
    res_err     = pngcp_pkg::ERR_NONE;
    res_rgba    = 32'd0;
    res_code    = 32'd0;
    err_v       = 1'b0;
    rgb_we      = 1'b0;
    rgb_waddr   = pal_cnt_r[AW-1:0];
    rgb_wdata   = {pal_rg_r, b};
    a_we        = 1'b0;
    a_waddr     = pal_cnt_r[AW-1:0];
    a_wdata     = pngcp_pkg::FULL_BYTE;
    rd_en       = 1'b0;
    raddr       = b[AW-1:0];

    if (accept && !failed_r && phase_r != PH_DONE) begin
      if (in_tlast) begin
        err_v   = 1'b1;
        res_err = pngcp_pkg::ERR_TRUNC;
      end else begin
        unique case (phase_r)
          PH_SIG: begin
            if (b != pngcp_pkg::sig_byte(cnt_r[2:0])) begin
              err_v   = 1'b1;
              res_err = pngcp_pkg::ERR_INVALID;
            end else if (cnt_r[2:0] == 3'd7) begin
              phase_nxt = PH_LEN;
              cnt_nxt   = 32'd0;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
          PH_LEN: begin
            len_nxt    = {len_r[23:0], b};
            len_m3_nxt = (cnt_r == 32'd0) ? pngcp_pkg::mod3({2'b00, b})
                                          : pngcp_pkg::mod3({len_m3_r, b});
            if (cnt_r == 32'd3) begin
              phase_nxt = PH_TYPE;
              cnt_nxt   = 32'd0;
              crc_nxt   = '1;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
          PH_TYPE: begin
            crc_nxt  = pngcp_pkg::crc_byte(crc_r, b);
            kind_nxt = {kind_r[23:0], b};
            if (cnt_r == 32'd3) begin
              cnt_nxt = 32'd0;
              case (kind_nxt)
                pngcp_pkg::KIND_IHDR: begin
                  if (len_r != 32'd13) begin
                    err_v   = 1'b1;
                    res_err = pngcp_pkg::ERR_INVALID;
                  end
                end
                pngcp_pkg::KIND_PLTE: begin
                  if (len_m3_r != 2'd0 || len_r > PLTE_MAX_LEN) begin
                    err_v   = 1'b1;
                    res_err = pngcp_pkg::ERR_INVALID;
                  end else begin
                    // The count is rebuilt entry by entry while the payload streams.
                    pal_cnt_nxt = '0;
                    pal_sub_nxt = 2'd0;
                  end
                end
                pngcp_pkg::KIND_TRNS: begin
                  case (color_r) inside
                    pngcp_pkg::COLOR_GRAY: err_v = (len_r != 32'd2);
                    pngcp_pkg::COLOR_RGB:  err_v = (len_r != 32'd6);
                    pngcp_pkg::COLOR_PAL:  err_v = (len_r > 32'(pal_cnt_r));
                    pngcp_pkg::COLOR_GRAYA,
                    pngcp_pkg::COLOR_RGBA: err_v = 1'b1;
                    default:               err_v = 1'b0;
                  endcase
                  res_err = pngcp_pkg::ERR_INVALID;
                end
                pngcp_pkg::KIND_IDAT: begin
                  if (bpp == 8'd0) begin
                    err_v   = 1'b1;
                    res_err = pngcp_pkg::ERR_UNSUPP;
                  end else if (color_r == pngcp_pkg::COLOR_PAL && pal_cnt_r == '0) begin
                    err_v   = 1'b1;
                    res_err = pngcp_pkg::ERR_INVALID;
                  end
                end
                default: ;
              endcase
              phase_nxt = (len_r == 32'd0) ? PH_CRC : PH_DATA;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
          PH_DATA: begin
            crc_nxt = pngcp_pkg::crc_byte(crc_r, b);
            if (cnt_inc >= len_r) begin
              phase_nxt = PH_CRC;
              cnt_nxt   = 32'd0;
            end else begin
              cnt_nxt = cnt_inc;
            end
            case (kind_r)
              pngcp_pkg::KIND_IHDR: begin
                if (cnt_r < 32'd4) begin
                  width_nxt = {width_r[23:0], b};
                end else if (cnt_r < 32'd8) begin
                  height_nxt = {height_r[23:0], b};
                end else if (cnt_r == 32'd8) begin
                  if (b != pngcp_pkg::SAMPLE_BITS) begin
                    err_v   = 1'b1;
                    res_err = pngcp_pkg::ERR_UNSUPP;
                  end
                end else if (cnt_r == 32'd9) begin
                  color_nxt = b;
                end else if (b != 8'd0) begin
                  err_v   = 1'b1;
                  res_err = pngcp_pkg::ERR_UNSUPP;
                end
              end
              pngcp_pkg::KIND_PLTE: begin
                case (pal_sub_r)
                  2'd0: begin
                    pal_rg_nxt  = {b, 8'd0};
                    a_we        = 1'b1;
                    pal_sub_nxt = 2'd1;
                  end
                  2'd1: begin
                    pal_rg_nxt  = {pal_rg_r[15:8], b};
                    pal_sub_nxt = 2'd2;
                  end
                  default: begin
                    rgb_we      = 1'b1;
                    pal_cnt_nxt = pal_cnt_r + CW'(1);
                    pal_sub_nxt = 2'd0;
                  end
                endcase
              end
              pngcp_pkg::KIND_TRNS: begin
                if (color_r == pngcp_pkg::COLOR_PAL && cnt_r < 32'(pal_cnt_r)) begin
                  a_we    = 1'b1;
                  a_waddr = cnt_r[AW-1:0];
                  a_wdata = b;
                end
              end
              pngcp_pkg::KIND_IDAT: begin
                if (total_r != '1) begin
                  total_nxt = total_r + 64'd1;
                end
                if (color_r == pngcp_pkg::COLOR_PAL) begin
                  if ({{(CW > 8 ? CW - 8 : 0){1'b0}}, b} >= pal_cnt_r) begin
                    err_v   = 1'b1;
                    res_err = pngcp_pkg::ERR_INVALID;
                  end else begin
                    rd_en      = 1'b1;
                    res_v      = 1'b1;
                    res_lookup = 1'b1;
                  end
                end else if (color_r == pngcp_pkg::COLOR_RGB ||
                             (color_r == pngcp_pkg::COLOR_RGBA && gcnt_r < 2'd3)) begin
                  gather_nxt = {gather_r[15:0], b};
                  gcnt_nxt   = gcnt_r + 2'd1;
                  if (color_r == pngcp_pkg::COLOR_RGB && gcnt_r == 2'd2) begin
                    gcnt_nxt = 2'd0;
                    res_v    = 1'b1;
                    res_rgba = {gather_r[15:0], b, pngcp_pkg::FULL_BYTE};
                  end
                end else if (color_r == pngcp_pkg::COLOR_RGBA) begin
                  gcnt_nxt = 2'd0;
                  res_v    = 1'b1;
                  res_rgba = {gather_r, b};
                end
              end
              default: ;
            endcase
          end
          PH_CRC: begin
            crc_rx_nxt = {crc_rx_r[23:0], b};
            if (cnt_r == 32'd3) begin
              cnt_nxt = 32'd0;
              if (~crc_r != crc_rx_nxt) begin
                err_v   = 1'b1;
                res_err = pngcp_pkg::ERR_INVALID;
              end else if (kind_r == pngcp_pkg::KIND_IEND) begin
                if (bpp == 8'd0) begin
                  err_v   = 1'b1;
                  res_err = pngcp_pkg::ERR_UNSUPP;
                end else if ((color_r == pngcp_pkg::COLOR_PAL && pal_cnt_r == '0) ||
                             total_r == '1 || {2'b00, total_r} != exp_bytes_r) begin
                  err_v   = 1'b1;
                  res_err = pngcp_pkg::ERR_INVALID;
                end else begin
                  phase_nxt = PH_DONE;
                  res_v     = 1'b1;
                  res_kind  = pngcp_pkg::RES_DONE;
                  res_code  = kind_r;
                end
              end else begin
                phase_nxt = PH_LEN;
                res_v     = 1'b1;
                res_kind  = pngcp_pkg::RES_CHUNK;
                res_code  = kind_r;
              end
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
          default: ;
        endcase
      end
      if (err_v) begin
        failed_nxt = 1'b1;
        res_v      = 1'b1;
        res_lookup = 1'b0;
        rd_en      = 1'b0;
        res_kind   = pngcp_pkg::RES_ERROR;
        res_rgba   = 32'd0;
        res_code   = 32'd0;
      end
    end
  end

  pngcp_ram #(.WIDTH(24), .DEPTH(PALETTE_DEPTH)) u_rgb_ram (
    .clk   (clk),
    .we    (rgb_we),
    .waddr (rgb_waddr),
    .wdata (rgb_wdata),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rgb_rdata)
  );

  pngcp_ram #(.WIDTH(8), .DEPTH(PALETTE_DEPTH)) u_alpha_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (a_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SIG;
      cnt_r       <= '0;
      len_r       <= '0;
      len_m3_r    <= '0;
      kind_r      <= '0;
      crc_r       <= '1;
      crc_rx_r    <= '0;
      width_r     <= '0;
      height_r    <= '0;
      color_r     <= '0;
      pal_cnt_r   <= '0;
      pal_sub_r   <= '0;
      pal_rg_r    <= '0;
      gather_r    <= '0;
      gcnt_r      <= '0;
      total_r     <= '0;
      failed_r    <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      len_r     <= len_nxt;
      len_m3_r  <= len_m3_nxt;
      kind_r    <= kind_nxt;
      crc_r     <= crc_nxt;
      crc_rx_r  <= crc_rx_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      color_r   <= color_nxt;
      pal_cnt_r <= pal_cnt_nxt;
      pal_sub_r <= pal_sub_nxt;
      pal_rg_r  <= pal_rg_nxt;
      gather_r  <= gather_nxt;
      gcnt_r    <= gcnt_nxt;
      total_r   <= total_nxt;
      failed_r  <= failed_nxt;
      if (in_tready) begin
        s1_valid_r <= accept && res_v;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
    // Image size products change only in the header, long before the end chunk is checked.
    exp_pix_r   <= width_r * height_r;
    exp_bytes_r <= exp_bytes;
    if (accept && res_v) begin
      s1_lookup_r <= res_lookup;
      s1_kind_r   <= res_kind;
      s1_err_r    <= res_err;
      s1_rgba_r   <= res_rgba;
      s1_code_r   <= res_code;
    end
    if (s1_adv && s1_valid_r) begin
      out_kind_r <= s1_kind_r;
      out_err_r  <= s1_err_r;
      out_code_r <= s1_code_r;
      out_rgba_r <= s1_lookup_r ? {rgb_rdata, a_rdata} : s1_rgba_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {6'd0, out_code_r, out_err_r, out_rgba_r[7:0], out_rgba_r[15:8],
                       out_rgba_r[23:16], out_rgba_r[31:24]};

endmodule
